// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the checker module.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (c)) else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, a, c, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (c)) else $error(msg);

`endif

// ===== rtl/core/tcw_pkg.sv =====
// Package for the text console writer: transaction structs and codes.
// No dependencies.
`default_nettype none

package tcw_pkg;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [7:0]  char_code;
		logic [10:0] cell_index;
	} req_t;

	typedef struct packed {
		logic [10:0] cursor_pos;
		logic [15:0] read_cell;
	} rsp_t;

	localparam logic [1:0] REQ_PUT   = 2'd0;
	localparam logic [1:0] REQ_READ  = 2'd1;
	localparam logic [1:0] REQ_CLEAR = 2'd2;

	localparam logic [7:0] CH_BS  = 8'd8;
	localparam logic [7:0] CH_TAB = 8'd9;
	localparam logic [7:0] CH_NL  = 8'd10;
	localparam logic [7:0] CH_CR  = 8'd13;

	localparam logic [7:0] BLANK_CHAR = 8'h20;
	localparam logic [7:0] RESET_ATTR = 8'd15;

	localparam logic [1:0] CUR_HOLD = 2'd0;
	localparam logic [1:0] CUR_HOME = 2'd1;
	localparam logic [1:0] CUR_LAST = 2'd2;
	localparam logic [1:0] CUR_PUT  = 2'd3;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] ch;
	} cur_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/core/tcw_screen_ram.sv =====
// Screen cell memory: one write port, one registered read port.
// No package dependencies.
`default_nettype none

module tcw_screen_ram #(
	parameter int DEPTH = 2000,
	parameter int AW    = 11
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [15:0]   wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [15:0]   rdata
);

	logic [15:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/tcw_cursor_unit.sv =====
// Cursor unit: linear cursor with tracked column and tab phase.
// Depends on tcw_pkg (cur_cmd_t, character and command codes).
`default_nettype none

module tcw_cursor_unit
	import tcw_pkg::*;
#(
	parameter int COLUMNS  = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STOP = 8,
	parameter int CW       = 11
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire cur_cmd_t      cmd,
	output logic      [CW-1:0] cursor,
	output logic               at_end
);

	localparam int CELLS  = ROWS * COLUMNS;
	localparam int COLW   = $clog2(COLUMNS + TAB_STOP + 1);
	localparam int TABW   = $clog2(TAB_STOP);
	localparam int BS_TAB = (COLUMNS - 1) % TAB_STOP;

	logic [CW-1:0]   cur_q, cur_d;
	logic [COLW-1:0] col_q, col_d, step, col_inc;
	logic [TABW-1:0] tab_q, tab_d;

	always_comb begin
		cur_d   = cur_q;
		col_d   = col_q;
		tab_d   = tab_q;
		step    = COLW'(TAB_STOP) - COLW'(tab_q);
		col_inc = col_q + COLW'(1);
		if (col_q + step > COLW'(COLUMNS)) begin
			step = COLW'(COLUMNS) - col_q;
		end
		case (cmd.op)
			CUR_HOME: begin
				cur_d = '0;
				col_d = '0;
				tab_d = '0;
			end
			CUR_LAST: begin
				cur_d = CW'(CELLS - COLUMNS);
				col_d = '0;
				tab_d = '0;
			end
			CUR_PUT: begin
				case (cmd.ch)
					CH_NL: begin
						cur_d = cur_q + CW'(COLUMNS) - CW'(col_q);
						col_d = '0;
						tab_d = '0;
					end
					CH_CR: begin
						cur_d = cur_q - CW'(col_q);
						col_d = '0;
						tab_d = '0;
					end
					CH_TAB: begin
						if (tab_q != '0) begin
							cur_d = cur_q + CW'(step);
							col_d = (col_q + step == COLW'(COLUMNS)) ? '0 : col_q + step;
							tab_d = '0;
						end
					end
					CH_BS: begin
						if (cur_q != '0) begin
							cur_d = cur_q - CW'(1);
							if (col_q == '0) begin
								col_d = COLW'(COLUMNS - 1);
								tab_d = TABW'(BS_TAB);
							end else begin
								col_d = col_q - COLW'(1);
								tab_d = (tab_q == '0) ? TABW'(TAB_STOP - 1) : tab_q - TABW'(1);
							end
						end
					end
					default: begin
						cur_d = cur_q + CW'(1);
						if (col_inc == COLW'(COLUMNS)) begin
							col_d = '0;
							tab_d = '0;
						end else begin
							col_d = col_inc;
							tab_d = (tab_q == TABW'(TAB_STOP - 1)) ? '0 : tab_q + TABW'(1);
						end
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			col_q <= '0;
			tab_q <= '0;
		end else begin
			cur_q <= cur_d;
			col_q <= col_d;
			tab_q <= tab_d;
		end
	end

	assign cursor = cur_q;
	assign at_end = (cur_q == CW'(CELLS));

endmodule

`default_nettype wire

// ===== rtl/core/text_console_writer.sv =====
// Text console writer top level: request sequencer, screen memory, cursor unit.
// Depends on tcw_pkg, tcw_screen_ram, tcw_cursor_unit.
//
// channel   direction  signals              handshake
// request   in         req (req_t)          start && !busy
// result    out        rsp (rsp_t)          done, one cycle, no stall
// attribute in         cfg_wdata            cfg_we
//
// A put with the cursor past the end first scrolls the screen up one row,
// through the single memory write port, and then blanks the last row.
// A clear writes one cell per cycle, then homes the cursor.
// After reset the screen is blanked with busy high.
// The result strobe is shown for one cycle; busy stays high through it.
`default_nettype none

module text_console_writer
	import tcw_pkg::*;
#(
	parameter int COLUMNS  = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STOP = 8
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire req_t       req,
	output logic            done,
	output rsp_t            rsp,
	input  wire logic       cfg_we,
	input  wire logic [7:0] cfg_wdata
);

	localparam int CELLS = ROWS * COLUMNS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(CELLS + 1);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_CLEAR  = 3'd1;
	localparam logic [2:0] S_SCROLL = 3'd2;
	localparam logic [2:0] S_FILL   = 3'd3;
	localparam logic [2:0] S_PUT    = 3'd4;
	localparam logic [2:0] S_READ   = 3'd5;
	localparam logic [2:0] S_EMIT   = 3'd6;

	logic [2:0]    state_q;
	logic [AW-1:0] ptr_q;
	logic [7:0]    attr_q;
	logic [15:0]   blank_q;
	logic          clr_req_q;
	logic [1:0]    req_q;
	logic [7:0]    ch_q;
	logic [AW-1:0] idx_q;
	logic          in_range_q;
	logic          v_s1;
	logic [AW-1:0] wa_s1;

	logic          mem_we;
	logic [AW-1:0] mem_waddr, mem_raddr;
	logic [15:0]   mem_wdata, mem_rdata;
	logic [15:0]   attr_blank;
	cur_cmd_t      cur_cmd;
	logic [CW-1:0] cursor;
	logic          at_end;

	assign attr_blank = {attr_q, BLANK_CHAR};

	tcw_screen_ram #(
		.DEPTH(CELLS),
		.AW   (AW)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	tcw_cursor_unit #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS),
		.TAB_STOP(TAB_STOP),
		.CW      (CW)
	) u_cursor (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cur_cmd),
		.cursor(cursor),
		.at_end(at_end)
	);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = attr_blank;
		mem_raddr = (state_q == S_SCROLL) ? ptr_q : idx_q;
		if (v_s1) begin
			mem_we    = 1'b1;
			mem_waddr = wa_s1;
			mem_wdata = mem_rdata;
		end else if (state_q == S_CLEAR) begin
			mem_we    = 1'b1;
			mem_wdata = blank_q;
		end else if (state_q == S_FILL) begin
			mem_we    = 1'b1;
		end else if (state_q == S_PUT) begin
			case (ch_q)
				CH_NL, CH_CR, CH_TAB: begin
				end
				CH_BS: begin
					mem_we    = (cursor != '0);
					mem_waddr = AW'(cursor - CW'(1));
				end
				default: begin
					mem_we    = 1'b1;
					mem_waddr = AW'(cursor);
					mem_wdata = {attr_q, ch_q};
				end
			endcase
		end
	end

	always_comb begin
		cur_cmd.op = CUR_HOLD;
		cur_cmd.ch = ch_q;
		case (state_q)
			S_CLEAR: begin
				if (ptr_q == AW'(CELLS - 1)) begin
					cur_cmd.op = CUR_HOME;
				end
			end
			S_FILL: begin
				if (!v_s1 && ptr_q == AW'(CELLS - 1)) begin
					cur_cmd.op = CUR_LAST;
				end
			end
			S_PUT: begin
				cur_cmd.op = CUR_PUT;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= RESET_ATTR;
		end else if (cfg_we) begin
			attr_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		wa_s1 <= ptr_q - AW'(COLUMNS);
		if (state_q == S_IDLE && start) begin
			req_q      <= req.req_type;
			ch_q       <= req.char_code;
			idx_q      <= AW'(req.cell_index);
			in_range_q <= (32'(req.cell_index) < 32'(CELLS));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLEAR;
			ptr_q     <= '0;
			blank_q   <= {RESET_ATTR, BLANK_CHAR};
			clr_req_q <= 1'b0;
			v_s1      <= 1'b0;
		end else begin
			v_s1 <= (state_q == S_SCROLL);
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (req.req_type)
							REQ_PUT: begin
								if (at_end) begin
									state_q <= S_SCROLL;
									ptr_q   <= AW'(COLUMNS);
								end else begin
									state_q <= S_PUT;
								end
							end
							REQ_READ: begin
								state_q <= S_READ;
							end
							REQ_CLEAR: begin
								state_q   <= S_CLEAR;
								ptr_q     <= '0;
								blank_q   <= attr_blank;
								clr_req_q <= 1'b1;
							end
							default: begin
								state_q <= S_EMIT;
							end
						endcase
					end
				end
				S_CLEAR: begin
					if (ptr_q == AW'(CELLS - 1)) begin
						state_q   <= clr_req_q ? S_EMIT : S_IDLE;
						clr_req_q <= 1'b0;
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				S_SCROLL: begin
					if (ptr_q == AW'(CELLS - 1)) begin
						state_q <= S_FILL;
						ptr_q   <= AW'(CELLS - COLUMNS);
					end else begin
						ptr_q <= ptr_q + AW'(1);
					end
				end
				S_FILL: begin
					if (!v_s1) begin
						if (ptr_q == AW'(CELLS - 1)) begin
							state_q <= S_PUT;
						end else begin
							ptr_q <= ptr_q + AW'(1);
						end
					end
				end
				S_PUT: begin
					state_q <= S_EMIT;
				end
				S_READ: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy           = (state_q != S_IDLE);
	assign done           = (state_q == S_EMIT);
	assign rsp.cursor_pos = 11'(cursor);
	assign rsp.read_cell  = (req_q == REQ_READ && in_range_q) ? mem_rdata : '0;

endmodule

`default_nettype wire

// ===== rtl/core/tcw_checker.sv =====
// Port-level checker for the text console writer, with its bind.
// Depends on tcw_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module tcw_port_props
	import tcw_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done,
	input wire rsp_t rsp
);

	localparam int CELLS = ROWS * COLUMNS;

	`ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accepted transaction did not raise busy")
	`ASSERT_IMPLIES(a_done_busy, clk, arst_n, done, busy, "result strobe while idle")
	`ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done, "result strobe longer than one cycle")
	`ASSERT_IMPLIES(a_cursor_range, clk, arst_n, done, 32'(rsp.cursor_pos) <= 32'(CELLS), "cursor beyond screen end")

endmodule

bind text_console_writer tcw_port_props #(
	.COLUMNS(COLUMNS),
	.ROWS   (ROWS)
) u_tcw_port_props (
	.clk   (clk),
	.arst_n(arst_n),
	.start (start),
	.busy  (busy),
	.done  (done),
	.rsp   (rsp)
);

`default_nettype wire
